// ===== rtl/kwd_pkg.sv =====
package kwd_pkg;

  localparam int unsigned TimeoutW = 16;
  localparam int unsigned StableW  = 18;
  localparam int unsigned PadW     = 32;
  localparam int unsigned PhaseW   = 3;
  localparam int unsigned CfgW     = 18;

  localparam logic [StableW-1:0] StableReset = 18'h26000;

  // Phase codes of the wait sequencer.
  localparam logic [PhaseW-1:0] PhIdle         = 3'd0;
  localparam logic [PhaseW-1:0] PhRelease      = 3'd1;
  localparam logic [PhaseW-1:0] PhPress        = 3'd2;
  localparam logic [PhaseW-1:0] PhConfirm      = 3'd3;
  localparam logic [PhaseW-1:0] PhComboSleep   = 3'd4;
  localparam logic [PhaseW-1:0] PhComboConfirm = 3'd5;
  localparam logic [PhaseW-1:0] PhComboCheck   = 3'd6;

  // Configuration register indexes.
  localparam logic CfgTimeout = 1'b0;
  localparam logic CfgStable  = 1'b1;

  typedef struct packed {
    logic            start_req;
    logic            mode;
    logic [PadW-1:0] keys;
    logic            ms_tick;
  } kwd_in_t;

  typedef struct packed {
    logic [PadW-1:0] result_keys;
    logic            timed_out;
  } kwd_out_t;

  typedef struct packed {
    logic [TimeoutW-1:0] timeout_ms;
    logic [StableW-1:0]  stable_samples;
  } kwd_cfg_t;

endpackage

// ===== rtl/kwd_step.sv =====
module kwd_step import kwd_pkg::*; #(
  parameter int unsigned KEY_BITS = 32
) (
  input  kwd_in_t             item_i,
  input  kwd_cfg_t            cfg_i,
  input  logic [PhaseW-1:0]   phase_i,
  input  logic [TimeoutW-1:0] elapsed_i,
  input  logic [KEY_BITS-1:0] latched_i,
  input  logic [StableW-1:0]  stable_left_i,
  input  logic [KEY_BITS-1:0] combo_i,
  input  logic                wait_kind_i,
  output logic [PhaseW-1:0]   phase_o,
  output logic [TimeoutW-1:0] elapsed_o,
  output logic [KEY_BITS-1:0] latched_o,
  output logic [StableW-1:0]  stable_left_o,
  output logic [KEY_BITS-1:0] combo_o,
  output logic                wait_kind_o,
  output logic                res_valid_o,
  output kwd_out_t            res_o
);

  logic [KEY_BITS-1:0] k;
  logic [TimeoutW-1:0] el_inc;
  logic [StableW-1:0]  stable_init;
  logic                keys_zero;
  logic                tick_cnt;
  logic [TimeoutW-1:0] el_new;
  logic                expired;

  assign k           = item_i.keys[KEY_BITS-1:0];
  assign keys_zero   = (k == '0);
  assign el_inc      = (elapsed_i != '1) ? elapsed_i + 1'b1 : elapsed_i;
  assign stable_init = (cfg_i.stable_samples == '0) ? StableW'(1) : cfg_i.stable_samples;

  // Ticks are counted while keys are held in release, and while idle in press.
  always_comb begin
    tick_cnt = 1'b0;
    case (phase_i)
      PhRelease: tick_cnt = item_i.ms_tick && !keys_zero;
      PhPress:   tick_cnt = item_i.ms_tick && keys_zero;
      default:   tick_cnt = 1'b0;
    endcase
  end

  assign el_new  = tick_cnt ? el_inc : elapsed_i;
  assign expired = (cfg_i.timeout_ms != '0) && (el_new >= cfg_i.timeout_ms);

  always_comb begin
    phase_o       = phase_i;
    elapsed_o     = elapsed_i;
    latched_o     = latched_i;
    stable_left_o = stable_left_i;
    combo_o       = combo_i;
    wait_kind_o   = wait_kind_i;
    res_valid_o   = 1'b0;
    res_o         = '0;
    if (item_i.start_req) begin
      wait_kind_o   = item_i.mode;
      elapsed_o     = '0;
      latched_o     = '0;
      stable_left_o = '0;
      combo_o       = '0;
      phase_o       = PhRelease;
    end else begin
      case (phase_i)
        PhRelease: begin
          elapsed_o = el_new;
          if (expired) begin
            res_valid_o     = 1'b1;
            res_o.timed_out = 1'b1;
            phase_o         = PhIdle;
          end else if (keys_zero) begin
            phase_o = wait_kind_i ? PhComboSleep : PhPress;
          end
        end
        PhPress: begin
          elapsed_o = el_new;
          if (expired) begin
            res_valid_o     = 1'b1;
            res_o.timed_out = 1'b1;
            phase_o         = PhIdle;
          end else if (!keys_zero) begin
            latched_o     = k;
            stable_left_o = stable_init;
            phase_o       = PhConfirm;
          end
        end
        PhConfirm: begin
          if (k != latched_i) begin
            if (!keys_zero) begin
              latched_o     = k;
              stable_left_o = stable_init;
            end else begin
              phase_o = PhPress;
            end
          end else begin
            stable_left_o = stable_left_i - 1'b1;
            if (stable_left_i == StableW'(1)) begin
              res_valid_o       = 1'b1;
              res_o.result_keys = PadW'(latched_i);
              phase_o           = PhIdle;
            end
          end
        end
        PhComboSleep: begin
          if (item_i.ms_tick) begin
            elapsed_o     = el_inc;
            latched_o     = k;
            stable_left_o = stable_init;
            phase_o       = PhComboConfirm;
          end
        end
        PhComboConfirm: begin
          if (k != latched_i) begin
            phase_o = PhComboCheck;
          end else begin
            stable_left_o = stable_left_i - 1'b1;
            if (stable_left_i == StableW'(1)) begin
              combo_o = latched_i;
              phase_o = PhComboCheck;
            end
          end
        end
        PhComboCheck: begin
          if (expired) begin
            res_valid_o     = 1'b1;
            res_o.timed_out = 1'b1;
            phase_o         = PhIdle;
          end else if ((combo_i != '0) && keys_zero) begin
            res_valid_o       = 1'b1;
            res_o.result_keys = PadW'(combo_i);
            phase_o           = PhIdle;
          end else begin
            phase_o = PhComboSleep;
          end
        end
        default: begin
          phase_o = PhIdle;
        end
      endcase
    end
  end

endmodule

// ===== rtl/kwd_out_reg.sv =====
module kwd_out_reg import kwd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     load_i,
  input  kwd_out_t data_i,
  output logic     free_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output kwd_out_t out_data_o
);

  logic     valid_q, valid_d;
  kwd_out_t data_q;

  // The slot can take a new result when empty or when its content leaves now.
  assign free_o  = !valid_q || !out_stall_i;
  assign valid_d = load_i ? 1'b1 : (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== rtl/key_wait_debouncer_core.sv =====
// The input transaction that ends the wait is held in the input register and processed once
// the result register is free; the result it causes is then offered from the result register.
// Throughput: one input transaction per cycle while the result register is free to take a result.
// Reset: asynchronous, active low; the sequencer returns to idle, all counters and
// latched keys clear, timeout_ms resets to zero and stable_samples to 0x26000.
module key_wait_debouncer_core import kwd_pkg::*; #(
  parameter int unsigned KEY_BITS = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  kwd_in_t         in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output kwd_out_t        out_data_o,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i
);

  // Configuration registers. The user is to write them only while the block is idle (the block
  // itself does not enforce this), so they feed the step logic directly.
  kwd_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_ms     <= '0;
      cfg_q.stable_samples <= StableReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgTimeout: cfg_q.timeout_ms     <= cfg_data_i[TimeoutW-1:0];
        CfgStable:  cfg_q.stable_samples <= cfg_data_i[StableW-1:0];
        default:    cfg_q <= cfg_q;
      endcase
    end
  end

  // Input register. The held transaction is processed once the result register can take
  // whatever it may produce; a new transaction is accepted in the same cycle.
  logic    in_valid_q;
  kwd_in_t in_data_q;
  logic    out_free;
  logic    advance;
  logic    accept;

  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept || advance) begin
      in_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_data_q <= in_data_i;
    end
  end

  // Wait state, advanced by one step for every processed transaction.
  logic [PhaseW-1:0]   phase_q, phase_d;
  logic [TimeoutW-1:0] elapsed_q, elapsed_d;
  logic [KEY_BITS-1:0] latched_q, latched_d;
  logic [StableW-1:0]  stable_left_q, stable_left_d;
  logic [KEY_BITS-1:0] combo_q, combo_d;
  logic                wait_kind_q, wait_kind_d;
  logic                res_valid;
  kwd_out_t            res;

  kwd_step #(
    .KEY_BITS(KEY_BITS)
  ) u_step (
    .item_i       (in_data_q),
    .cfg_i        (cfg_q),
    .phase_i      (phase_q),
    .elapsed_i    (elapsed_q),
    .latched_i    (latched_q),
    .stable_left_i(stable_left_q),
    .combo_i      (combo_q),
    .wait_kind_i  (wait_kind_q),
    .phase_o      (phase_d),
    .elapsed_o    (elapsed_d),
    .latched_o    (latched_d),
    .stable_left_o(stable_left_d),
    .combo_o      (combo_d),
    .wait_kind_o  (wait_kind_d),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PhIdle;
      elapsed_q     <= '0;
      latched_q     <= '0;
      stable_left_q <= '0;
      combo_q       <= '0;
      wait_kind_q   <= 1'b0;
    end else if (advance) begin
      phase_q       <= phase_d;
      elapsed_q     <= elapsed_d;
      latched_q     <= latched_d;
      stable_left_q <= stable_left_d;
      combo_q       <= combo_d;
      wait_kind_q   <= wait_kind_d;
    end
  end

  // Result register. Its free flag passes the output stall combinationally on to the input stall.
  kwd_out_reg u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance && res_valid),
    .data_i     (res),
    .free_o     (out_free),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

// ===== verif/key_wait_debouncer_core_test.sv =====
`timescale 1ns / 1ps

module key_wait_debouncer_core_test import kwd_pkg::*;;

  localparam int unsigned KeyBits    = 32;
  localparam int unsigned CycleLimit = 600000;
  localparam logic [PadW-1:0] KeyMask = {PadW{1'b1}} >> (PadW - KeyBits);

  // Mirror of the wait sequencer. Every accepted input transaction is applied
  // to a private copy of the state and configuration; any result that the
  // transaction causes is queued until the block hands it over.
  class wait_outcome_tracker;
    logic [TimeoutW-1:0] timeout_ms;
    logic [StableW-1:0]  stable_samples;
    logic [PhaseW-1:0]   phase;
    logic [15:0]         elapsed_ms;
    logic [PadW-1:0]     latched_keys;
    logic [StableW-1:0]  stable_left;
    logic [PadW-1:0]     combo_keys;
    logic                wait_kind;
    kwd_out_t            expected_outcomes[$];
    int unsigned         mismatches;

    function new();
      timeout_ms     = '0;
      stable_samples = StableReset;
      phase          = PhIdle;
      elapsed_ms     = '0;
      latched_keys   = '0;
      stable_left    = '0;
      combo_keys     = '0;
      wait_kind      = 1'b0;
      mismatches     = 0;
    endfunction

    function void write_reg(logic idx, logic [CfgW-1:0] val);
      if (idx == CfgTimeout) begin
        timeout_ms = val[TimeoutW-1:0];
      end else begin
        stable_samples = val[StableW-1:0];
      end
    endfunction

    function int outstanding();
      return expected_outcomes.size();
    endfunction

    function bit timed_up();
      return timeout_ms != 0 && elapsed_ms >= timeout_ms;
    endfunction

    function void bump_elapsed();
      if (elapsed_ms != 16'hFFFF) elapsed_ms++;
    endfunction

    function void arm(logic [PadW-1:0] k, logic [PhaseW-1:0] next);
      latched_keys = k;
      stable_left  = (stable_samples == 0) ? 1 : stable_samples;
      phase        = next;
    endfunction

    function void end_wait(logic [PadW-1:0] k, logic to);
      kwd_out_t r;
      r.result_keys = k;
      r.timed_out   = to;
      expected_outcomes.push_back(r);
      phase = PhIdle;
    endfunction

    function void absorb(kwd_in_t it);
      logic [PadW-1:0] k;
      k = it.keys & KeyMask;
      if (it.start_req) begin
        wait_kind    = it.mode;
        elapsed_ms   = '0;
        latched_keys = '0;
        stable_left  = '0;
        combo_keys   = '0;
        phase        = PhRelease;
        return;
      end
      case (phase)
        PhRelease: begin
          if (k != 0 && it.ms_tick) bump_elapsed();
          if (timed_up()) end_wait('0, 1'b1);
          else if (k == 0) phase = wait_kind ? PhComboSleep : PhPress;
        end
        PhPress: begin
          if (k == 0 && it.ms_tick) bump_elapsed();
          if (timed_up()) end_wait('0, 1'b1);
          else if (k != 0) arm(k, PhConfirm);
        end
        PhConfirm: begin
          if (k != latched_keys) begin
            if (k != 0) arm(k, PhConfirm);
            else phase = PhPress;
          end else begin
            stable_left--;
            if (stable_left == 0) end_wait(latched_keys, 1'b0);
          end
        end
        PhComboSleep: begin
          if (it.ms_tick) begin
            bump_elapsed();
            arm(k, PhComboConfirm);
          end
        end
        PhComboConfirm: begin
          if (k != latched_keys) begin
            phase = PhComboCheck;
          end else begin
            stable_left--;
            if (stable_left == 0) begin
              combo_keys = latched_keys;
              phase      = PhComboCheck;
            end
          end
        end
        PhComboCheck: begin
          if (timed_up()) end_wait('0, 1'b1);
          else if (combo_keys != 0 && k == 0) end_wait(combo_keys, 1'b0);
          else phase = PhComboSleep;
        end
        default: phase = PhIdle;
      endcase
    endfunction

    function void compare(kwd_out_t got);
      kwd_out_t want;
      if (expected_outcomes.size() == 0) begin
        $error("unexpected result: result_keys %08h timed_out %0b",
               got.result_keys, got.timed_out);
        mismatches++;
        return;
      end
      want = expected_outcomes.pop_front();
      if (got.result_keys !== want.result_keys) begin
        $error("result_keys: expected %08h, got %08h", want.result_keys, got.result_keys);
        mismatches++;
      end
      if (got.timed_out !== want.timed_out) begin
        $error("timed_out: expected %0b, got %0b", want.timed_out, got.timed_out);
        mismatches++;
      end
    endfunction
  endclass

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_stall_o;
  kwd_in_t         in_data_i;
  logic            out_valid_o;
  logic            out_stall_i;
  kwd_out_t        out_data_o;
  logic            cfg_we_i;
  logic            cfg_idx_i;
  logic [CfgW-1:0] cfg_data_i;

  wait_outcome_tracker book = new();

  // Idling controls. src_gaps and sink_gaps switch the random bubbles on each
  // side; hold_cycles, when loaded, makes the receiver refuse results for that
  // many cycles regardless of anything else.
  bit          src_gaps    = 1'b1;
  bit          sink_gaps   = 1'b1;
  int unsigned hold_cycles = 0;
  int unsigned offered     = 0;
  int unsigned cycles      = 0;

  always #6 clk_i = ~clk_i;

  key_wait_debouncer_core #(
    .KEY_BITS(KeyBits)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  function automatic logic coin();
    return 1'($urandom_range(1));
  endfunction

  function automatic kwd_in_t pad_item(logic s, logic m, logic [PadW-1:0] k, logic t);
    kwd_in_t r;
    r.start_req = s;
    r.mode      = m;
    r.keys      = k;
    r.ms_tick   = t;
    return r;
  endfunction

  // A pressed pattern: never zero, drawn so that every key bit is seen both
  // set and clear over the run, with some repeats to let samples match.
  function automatic logic [PadW-1:0] press_keys();
    logic [PadW-1:0] k;
    do begin
      case ($urandom_range(4))
        0:       k = $urandom();
        1:       k = 32'h1 << $urandom_range(31);
        2:       k = '1;
        3:       k = $urandom() & $urandom();
        default: k = 32'($urandom_range(1, 3));
      endcase
    end while (k == 0);
    return k;
  endfunction

  // The sender. The item is put on the bus at a falling edge, possibly after
  // a one-cycle bubble, and the task returns at the rising edge where the
  // transaction is taken. Valid is left high so that a following call can
  // carry straight on without a gap; drain lowers it.
  task automatic offer(input kwd_in_t item);
    @(negedge clk_i);
    if (src_gaps && $urandom_range(99) < 8) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_data_i  <= item;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    book.absorb(item);
    offered++;
  endtask

  // Takes the bus down and waits until every predicted result has been
  // handed over, and then also lets a transaction that is still passing
  // through the input register without causing a result go through.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (book.outstanding() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_reg(input logic idx, input logic [CfgW-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    book.write_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Number of matching samples to send after the latching one. At very large
  // settings the confirmation is deliberately left unfinished.
  function automatic int hold_len();
    if (book.stable_samples > 16) return $urandom_range(1, 6);
    return (book.stable_samples == 0) ? 1 : int'(book.stable_samples);
  endfunction

  // Single-key wait: start, a few samples with keys still down, the release,
  // some empty samples, then a press held long enough to be confirmed. Now
  // and then one sample of the hold is disturbed.
  task automatic press_and_hold(input int hold);
    logic [PadW-1:0] k;
    int              bad_at;
    k      = press_keys();
    bad_at = ($urandom_range(6) == 0) ? $urandom_range(0, hold - 1) : -1;
    offer(pad_item(1'b1, 1'b0, $urandom(), coin()));
    repeat ($urandom_range(0, 2)) offer(pad_item(1'b0, coin(), press_keys(), coin()));
    offer(pad_item(1'b0, coin(), '0, coin()));
    repeat ($urandom_range(0, 2)) offer(pad_item(1'b0, coin(), '0, coin()));
    offer(pad_item(1'b0, coin(), k, coin()));
    for (int i = 0; i < hold; i++) begin
      if (i == bad_at) offer(pad_item(1'b0, coin(), coin() ? '0 : press_keys(), coin()));
      offer(pad_item(1'b0, coin(), k, coin()));
    end
  endtask

  // Combination wait: after the release each round sleeps until a tick,
  // latches the pad, holds it, and then gives the check sample. Only the last
  // round releases the pad so that the wait can finish.
  task automatic combo_and_release(input int hold, input int rounds);
    logic [PadW-1:0] k;
    offer(pad_item(1'b1, 1'b1, $urandom(), coin()));
    repeat ($urandom_range(0, 2)) offer(pad_item(1'b0, coin(), press_keys(), coin()));
    offer(pad_item(1'b0, coin(), '0, coin()));
    for (int r = 0; r < rounds; r++) begin
      k = press_keys();
      repeat ($urandom_range(0, 2)) offer(pad_item(1'b0, coin(), $urandom(), 1'b0));
      offer(pad_item(1'b0, coin(), k, 1'b1));
      repeat (hold) offer(pad_item(1'b0, coin(), k, coin()));
      offer(pad_item(1'b0, coin(), (r == rounds - 1) ? '0 : press_keys(), coin()));
    end
  endtask

  // Loose samples from a small alphabet, so that stray matches still happen.
  task automatic pad_noise(input int n);
    logic [PadW-1:0] k;
    repeat (n) begin
      case ($urandom_range(4))
        0:       k = '0;
        1:       k = 32'h1;
        2:       k = 32'h3;
        3:       k = '1;
        default: k = $urandom();
      endcase
      offer(pad_item($urandom_range(19) == 0, coin(), k, coin()));
    end
  endtask

  // Result monitor: a result transaction completes at a rising edge where
  // valid is high and the receiver is not stalling.
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) book.compare(out_data_o);
    end
  end

  // Receiver. A loaded hold-off takes priority over the random stalls.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall_i <= sink_gaps && ($urandom_range(99) < 8);
      end
    end
  end

  // Watchdog on the total run length.
  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("key_wait_debouncer_core test failed");
    $finish;
  end

  initial begin
    int unsigned first;
    int unsigned pick;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CfgTimeout;
    cfg_data_i = '0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    set_reg(CfgStable, 1);
    set_reg(CfgTimeout, 0);

    // Directed opening: a sample while idle, a full single-key wait with the
    // widest pattern, restarts of the confirmation by a different key and by
    // a release, a start that drops a running wait, a full combination wait,
    // and a combination confirmed as empty which cannot end the wait.
    offer(pad_item(1'b0, 1'b0, '1, 1'b1));
    offer(pad_item(1'b1, 1'b0, '1, 1'b1));
    offer(pad_item(1'b0, 1'b1, '1, 1'b1));
    offer(pad_item(1'b0, 1'b0, '0, 1'b0));
    offer(pad_item(1'b0, 1'b0, 32'h8000_0001, 1'b1));
    offer(pad_item(1'b0, 1'b0, 32'h8000_0001, 1'b1));
    offer(pad_item(1'b1, 1'b0, '0, 1'b0));
    offer(pad_item(1'b0, 1'b0, '0, 1'b1));
    offer(pad_item(1'b0, 1'b0, '0, 1'b1));
    offer(pad_item(1'b0, 1'b0, 32'h1, 1'b0));
    offer(pad_item(1'b0, 1'b0, 32'h2, 1'b0));
    offer(pad_item(1'b0, 1'b0, '0, 1'b0));
    offer(pad_item(1'b0, 1'b0, 32'h4, 1'b0));
    offer(pad_item(1'b1, 1'b1, '1, 1'b0));
    offer(pad_item(1'b0, 1'b0, '0, 1'b0));
    offer(pad_item(1'b0, 1'b0, 32'h3, 1'b0));
    offer(pad_item(1'b0, 1'b1, 32'h3, 1'b1));
    offer(pad_item(1'b0, 1'b0, 32'h3, 1'b0));
    offer(pad_item(1'b0, 1'b0, '0, 1'b0));
    offer(pad_item(1'b1, 1'b1, '0, 1'b0));
    offer(pad_item(1'b0, 1'b0, '0, 1'b0));
    offer(pad_item(1'b0, 1'b0, '0, 1'b1));
    offer(pad_item(1'b0, 1'b0, '0, 1'b0));
    offer(pad_item(1'b0, 1'b0, '0, 1'b0));
    offer(pad_item(1'b0, 1'b0, 32'h5, 1'b1));
    drain();

    // Timeout reached while keys are still held after the start.
    set_reg(CfgTimeout, 2);
    offer(pad_item(1'b1, 1'b0, '1, 1'b0));
    offer(pad_item(1'b0, 1'b0, 32'h1, 1'b1));
    offer(pad_item(1'b0, 1'b0, 32'h1, 1'b1));
    drain();

    // A combination released after the tick that reaches the limit: the
    // timeout has to win over the release.
    set_reg(CfgTimeout, 1);
    offer(pad_item(1'b1, 1'b1, '0, 1'b0));
    offer(pad_item(1'b0, 1'b0, '0, 1'b0));
    offer(pad_item(1'b0, 1'b0, 32'h7, 1'b1));
    offer(pad_item(1'b0, 1'b0, 32'h7, 1'b0));
    offer(pad_item(1'b0, 1'b0, '0, 1'b0));
    drain();

    // The limit is lowered under a running wait; the next check must fire.
    set_reg(CfgTimeout, 100);
    offer(pad_item(1'b1, 1'b0, '0, 1'b0));
    repeat (5) offer(pad_item(1'b0, 1'b0, 32'h2, 1'b1));
    drain();
    set_reg(CfgTimeout, 4);
    offer(pad_item(1'b0, 1'b0, 32'h2, 1'b0));
    drain();

    // A stable count of zero behaves as one.
    set_reg(CfgTimeout, 0);
    set_reg(CfgStable, 0);
    press_and_hold(1);
    drain();

    // Back-pressure: the receiver refuses results for a long stretch while
    // short single-key waits keep coming, so the result path fills up and
    // the block has to stall its input. The sender then stops until every
    // result has been taken.
    set_reg(CfgTimeout, 0);
    set_reg(CfgStable, 1);
    src_gaps    = 1'b0;
    hold_cycles = 400;
    repeat (30) press_and_hold(1);
    drain();
    src_gaps = 1'b1;

    // Largest stable count: confirmation never completes, only timeouts end
    // the waits.
    set_reg(CfgStable, 18'h3FFFF);
    set_reg(CfgTimeout, $urandom_range(2, 12));
    repeat (3) begin
      press_and_hold(hold_len());
      combo_and_release(hold_len(), 2);
    end
    drain();

    // Random phases, each under its own configuration. Phase four runs
    // without any idling on either side.
    for (int p = 0; p < 10; p++) begin
      drain();
      case ($urandom_range(3))
        0:       set_reg(CfgTimeout, 0);
        1:       set_reg(CfgTimeout, $urandom_range(1, 40));
        2:       set_reg(CfgTimeout, $urandom_range(40, 65535));
        default: set_reg(CfgTimeout, 16'hFFFF);
      endcase
      set_reg(CfgStable, $urandom_range(0, 5));
      src_gaps  = (p != 4);
      sink_gaps = (p != 4);
      first     = offered;
      while (offered - first < 30) begin
        pick = $urandom_range(99);
        if (pick < 40) press_and_hold(hold_len());
        else if (pick < 80) combo_and_release(hold_len(), $urandom_range(1, 3));
        else if (pick < 90) pad_noise($urandom_range(3, 10));
        else begin
          offer(pad_item(1'b1, coin(), $urandom(), coin()));
          pad_noise($urandom_range(2, 6));
        end
      end
    end
    drain();

    if (book.mismatches == 0) begin
      $display("key_wait_debouncer_core test passed");
    end else begin
      $display("key_wait_debouncer_core test failed");
    end
    $finish;
  end

endmodule
